// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; compiled away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/u8fa_pkg.sv
// ----------------------------------------------------------------------------
// u8fa_pkg
// Types, constants and the Latin letter folding table of the UTF-8 folder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8fa_pkg;

  localparam int CP_W = 21;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  typedef struct packed {
    logic [CP_W-1:0] cp;   // code point bits gathered so far
    logic [1:0]      rem;  // continuation bytes still expected
    logic            bad;  // sequence saw a bad continuation
  } state_t;

  typedef struct packed {
    logic       two;
    logic [6:0] c0;
    logic [6:0] c1;
  } fold_t;

  typedef struct packed {
    state_t     nxt;
    logic       emit;  // at least one result for this byte
    logic       has;   // first result carries a character
    logic       two;   // a second character follows
    logic [6:0] c0;
    logic [6:0] c1;
  } dec_t;

  function automatic fold_t f1(logic [7:0] a);
    fold_t f;
    f.two = 1'b0;
    f.c0  = a[6:0];
    f.c1  = 7'd0;
    return f;
  endfunction

  function automatic fold_t f2(logic [7:0] a, logic [7:0] b);
    fold_t f;
    f.two = 1'b1;
    f.c0  = a[6:0];
    f.c1  = b[6:0];
    return f;
  endfunction

  // Fold Latin-1 and Latin Extended-A letters; everything else is '?'.
  function automatic fold_t fold_letter(logic [CP_W-1:0] code);
    fold_t f;
    f = f1(CH_QMARK);
    if (code[CP_W-1:9] == '0) begin
      case (code[8:0])
        9'h0C0, 9'h0C1, 9'h0C2, 9'h0C3, 9'h0C5: f = f1("A");
        9'h0C4: f = f2("A", "e");
        9'h0C6: f = f2("A", "E");
        9'h0C7: f = f1("C");
        9'h0C8, 9'h0C9, 9'h0CA, 9'h0CB: f = f1("E");
        9'h0CC, 9'h0CD, 9'h0CE, 9'h0CF: f = f1("I");
        9'h0D1: f = f1("N");
        9'h0D2, 9'h0D3, 9'h0D4, 9'h0D5, 9'h0D8: f = f1("O");
        9'h0D6: f = f2("O", "e");
        9'h0D9, 9'h0DA, 9'h0DB: f = f1("U");
        9'h0DC: f = f2("U", "e");
        9'h0DD: f = f1("Y");
        9'h0DF: f = f2("s", "s");
        9'h0E0, 9'h0E1, 9'h0E2, 9'h0E3, 9'h0E5: f = f1("a");
        9'h0E4, 9'h0E6: f = f2("a", "e");
        9'h0E7: f = f1("c");
        9'h0E8, 9'h0E9, 9'h0EA, 9'h0EB: f = f1("e");
        9'h0EC, 9'h0ED, 9'h0EE, 9'h0EF: f = f1("i");
        9'h0F1: f = f1("n");
        9'h0F2, 9'h0F3, 9'h0F4, 9'h0F5, 9'h0F8: f = f1("o");
        9'h0F6: f = f2("o", "e");
        9'h0F9, 9'h0FA, 9'h0FB: f = f1("u");
        9'h0FC: f = f2("u", "e");
        9'h0FD, 9'h0FF: f = f1("y");
        9'h102, 9'h104: f = f1("A");
        9'h103, 9'h105: f = f1("a");
        9'h106, 9'h10C: f = f1("C");
        9'h107, 9'h10D: f = f1("c");
        9'h10E, 9'h110: f = f1("D");
        9'h10F, 9'h111: f = f1("d");
        9'h118, 9'h11A: f = f1("E");
        9'h119, 9'h11B: f = f1("e");
        9'h141: f = f1("L");
        9'h142: f = f1("l");
        9'h143, 9'h147: f = f1("N");
        9'h144, 9'h148: f = f1("n");
        9'h150: f = f1("O");
        9'h151: f = f1("o");
        9'h158: f = f1("R");
        9'h159: f = f1("r");
        9'h15A, 9'h160: f = f1("S");
        9'h15B, 9'h161: f = f1("s");
        9'h164: f = f1("T");
        9'h165: f = f1("t");
        9'h16E, 9'h170: f = f1("U");
        9'h16F, 9'h171: f = f1("u");
        9'h179, 9'h17B, 9'h17D: f = f1("Z");
        9'h17A, 9'h17C, 9'h17E: f = f1("z");
        default: f = f1(CH_QMARK);
      endcase
    end
    return f;
  endfunction

endpackage

// File: rtl/u8fa_in_if.sv
// ----------------------------------------------------------------------------
// u8fa_in_if
// Byte channel into the folder: valid/ready with one text byte per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u8fa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

// File: rtl/u8fa_out_if.sv
// ----------------------------------------------------------------------------
// u8fa_out_if
// Character channel out of the folder: valid/ready with one result per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u8fa_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] ascii_char;
  logic       has_char;
  logic       run_last;
  logic       text_end;

  modport source (output valid, output ascii_char, output has_char,
                  output run_last, output text_end, input ready);
  modport sink   (input valid, input ascii_char, input has_char,
                  input run_last, input text_end, output ready);
endinterface

// File: rtl/utf8_to_folded_ascii.sv
// Path: an input transfer passes the input register, then the result register.
// Throughput: one byte per cycle while the output accepts results; a byte that
//   folds to two letters holds the next result back until its second letter transfers.
// Reset: synchronous, active low; clears the decoder state and all valid flags.
// ----------------------------------------------------------------------------
// utf8_to_folded_ascii
// UTF-8 byte stream to printable ASCII with Latin letter transliteration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_to_folded_ascii (
  input  logic              clk,
  input  logic              rst_n,
  u8fa_in_if.sink           in_ch,
  u8fa_out_if.source        out_ch
);

  // Input register stage: holds one accepted byte.
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Decoder state, updated as a byte leaves the input register.
  u8fa_pkg::state_t st_r;

  // Result register plus a slot for the second letter of a two-letter fold.
  logic       out_v_r;
  logic [6:0] out_char_r;
  logic       out_has_r;
  logic       out_run_r;
  logic       out_end_r;
  logic       sec_v_r;
  logic [6:0] sec_char_r;
  logic       sec_end_r;

  u8fa_pkg::dec_t dec;

  logic slot_free;
  logic advance;
  logic load;
  logic out_xfer;

  u8fa_decode u_dec (
    .st        (st_r),
    .text_byte (in_byte_r),
    .text_last (in_last_r),
    .dec       (dec)
  );

  // The result register frees up when it is empty or its final result transfers.
  assign out_xfer  = out_v_r && out_ch.ready;
  assign slot_free = !out_v_r || (out_ch.ready && !sec_v_r);
  // A byte with no result never waits on the output side.
  assign advance   = in_v_r && (!dec.emit || slot_free);
  assign load      = advance && dec.emit;

  assign in_ch.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.text_byte;
      in_last_r <= in_ch.text_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= dec.nxt;
    end
  end

  // Result valid flags: shift the second letter forward, load a new byte,
  // or drop the flag once the result transfers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sec_v_r <= 1'b0;
    end else if (out_xfer && sec_v_r) begin
      sec_v_r <= 1'b0;
    end else if (load) begin
      out_v_r <= 1'b1;
      sec_v_r <= dec.two;
    end else if (out_xfer) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer && sec_v_r) begin
      out_char_r <= sec_char_r;
      out_has_r  <= 1'b1;
      out_run_r  <= 1'b1;
      out_end_r  <= sec_end_r;
    end else if (load) begin
      out_char_r <= dec.c0;
      out_has_r  <= dec.has;
      out_run_r  <= !dec.two;
      out_end_r  <= in_last_r && !dec.two;
      sec_char_r <= dec.c1;
      sec_end_r  <= in_last_r;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.ascii_char = out_char_r;
  assign out_ch.has_char   = out_has_r;
  assign out_ch.run_last   = out_run_r;
  assign out_ch.text_end   = out_end_r;

  // A pending second letter always sits behind a valid first result.
  `ASSERT_IMPL(a_sec_behind_out, sec_v_r, out_v_r, "second letter without a result ahead")
  // A bare end marker closes both the byte's run and the text.
  `ASSERT_IMPL(a_marker_ends, out_v_r && !out_has_r, out_run_r && out_end_r,
               "end marker without run_last and text_end")
  // Decoder state is clear after the final byte of a text.
  `ASSERT_NEXT(a_idle_after_end, advance && in_last_r, st_r == '0,
               "decoder state not cleared at end of text")

endmodule

// File: rtl/u8fa_decode.sv
// ----------------------------------------------------------------------------
// u8fa_decode
// One UTF-8 byte step: next decoder state and the characters it yields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8fa_decode (
  input  u8fa_pkg::state_t st,
  input  logic [7:0]       text_byte,
  input  logic             text_last,
  output u8fa_pkg::dec_t   dec
);

  u8fa_pkg::fold_t fold;
  u8fa_pkg::state_t nx;
  logic             done;
  logic             n1;
  logic             cont_ok;

  always_comb begin
    nx      = st;
    done    = 1'b0;
    n1      = 1'b0;
    cont_ok = (text_byte[7:6] == 2'b10);
    dec.c0  = 7'd0;
    dec.c1  = 7'd0;
    dec.two = 1'b0;
    fold    = u8fa_pkg::f1(u8fa_pkg::CH_QMARK);

    if (st.rem == 2'd0) begin
      if (!text_byte[7]) begin
        n1 = 1'b1;
        if (text_byte >= u8fa_pkg::CH_SPACE && text_byte < u8fa_pkg::CH_DEL) begin
          dec.c0 = text_byte[6:0];
        end else begin
          dec.c0 = u8fa_pkg::CH_SPACE[6:0];
        end
      end else if (text_byte[7:5] == 3'b110) begin
        nx.cp  = u8fa_pkg::CP_W'(text_byte[4:0]);
        nx.rem = 2'd1;
        nx.bad = 1'b0;
      end else if (text_byte[7:4] == 4'b1110) begin
        nx.cp  = u8fa_pkg::CP_W'(text_byte[3:0]);
        nx.rem = 2'd2;
        nx.bad = 1'b0;
      end else if (text_byte[7:3] == 5'b11110) begin
        nx.cp  = u8fa_pkg::CP_W'(text_byte[2:0]);
        nx.rem = 2'd3;
        nx.bad = 1'b0;
      end
    end else begin
      // Gather six bits per good continuation; a bad one poisons the sequence.
      if (!cont_ok) begin
        nx.bad = 1'b1;
      end else if (!st.bad) begin
        nx.cp = {st.cp[u8fa_pkg::CP_W-7:0], text_byte[5:0]};
      end
      nx.rem = 2'(st.rem - 2'd1);
      if (nx.rem == 2'd0) begin
        done = !nx.bad;
        fold = u8fa_pkg::fold_letter(nx.cp);
        nx.cp  = '0;
        nx.bad = 1'b0;
      end
    end

    if (done) begin
      n1      = 1'b1;
      dec.c0  = fold.c0;
      dec.c1  = fold.c1;
      dec.two = fold.two;
    end

    // End of text drops any open sequence.
    if (text_last) begin
      nx = '0;
    end

    dec.nxt  = nx;
    dec.has  = n1;
    dec.emit = n1 || text_last;
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 to folded ASCII converter: a directed
// table of edge cases, then random texts built mostly from well-formed
// sequences, each transfer checked against a behavioral decoder in the bench.
// ----------------------------------------------------------------------------

module tb;

  // One result as it leaves the block.
  typedef struct packed {
    logic [6:0] ascii_char;
    logic       has_char;
    logic       run_last;
    logic       text_end;
  } glyph_t;

  // One or two letters that a code point folds to.
  typedef struct packed {
    logic       two;
    logic [6:0] first;
    logic [6:0] second;
  } letters_t;

  // A directed row: the byte, its end flag, and optionally the one result it
  // must give; rows without a typed result fall back on the decoder below.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_last;
    logic       typed;
    glyph_t     want;
  } stim_row_t;

  localparam int WATCHDOG  = 1000;  // cycles with no transfer on either side
  localparam int DRAIN     = 12;    // quiet cycles after the last result
  localparam int N_RANDOM  = 400;
  localparam int CALM_FROM = 340;   // no idling from here on

  localparam glyph_t NO_GLYPH = '0;
  localparam glyph_t END_MARK = {7'h00, 1'b0, 1'b1, 1'b1};

  localparam int N_DIRECTED = 24;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // ASCII extremes: controls and DEL become a space, printables pass
    {8'h00, 1'b0, 1'b1, 7'h20, 1'b1, 1'b1, 1'b0},
    {8'h20, 1'b0, 1'b1, 7'h20, 1'b1, 1'b1, 1'b0},
    {8'h7E, 1'b0, 1'b1, 7'h7E, 1'b1, 1'b1, 1'b0},
    {8'h7F, 1'b0, 1'b1, 7'h20, 1'b1, 1'b1, 1'b0},
    {8'h41, 1'b1, 1'b1, 7'h41, 1'b1, 1'b1, 1'b1},
    // stray bytes: dropped, and a stray end byte leaves a bare end marker
    {8'h80, 1'b0, 1'b0, NO_GLYPH},
    {8'hFF, 1'b1, 1'b1, END_MARK},
    // sharp s: two letters, the end flag on the second
    {8'hC3, 1'b0, 1'b0, NO_GLYPH},
    {8'h9F, 1'b1, 1'b0, NO_GLYPH},
    // three-byte sign outside the Latin blocks
    {8'hE2, 1'b0, 1'b0, NO_GLYPH},
    {8'h82, 1'b0, 1'b0, NO_GLYPH},
    {8'hAC, 1'b0, 1'b0, NO_GLYPH},
    // four-byte code point
    {8'hF0, 1'b0, 1'b0, NO_GLYPH},
    {8'h9F, 1'b0, 1'b0, NO_GLYPH},
    {8'h98, 1'b0, 1'b0, NO_GLYPH},
    {8'h80, 1'b0, 1'b0, NO_GLYPH},
    // bad continuation swallows the ASCII byte in its slot
    {8'hC3, 1'b0, 1'b0, NO_GLYPH},
    {8'h41, 1'b0, 1'b0, NO_GLYPH},
    // sequence cut short by the end of text
    {8'hE2, 1'b0, 1'b0, NO_GLYPH},
    {8'h82, 1'b1, 1'b1, END_MARK},
    // largest lead with all-ones payload: out of range, folds to '?'
    {8'hF7, 1'b0, 1'b0, NO_GLYPH},
    {8'hBF, 1'b0, 1'b0, NO_GLYPH},
    {8'hBF, 1'b0, 1'b0, NO_GLYPH},
    {8'hBF, 1'b1, 1'b1, {7'h3F, 1'b1, 1'b1, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst_n;

  u8fa_in_if  in_ch ();
  u8fa_out_if out_ch ();

  utf8_to_folded_ascii u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Decoder state of the bench's own model.
  logic [u8fa_pkg::CP_W-1:0] cp_acc;
  logic [1:0]                cont_left;
  logic                      seq_broken;

  glyph_t glyph_q[$];   // results still owed by the block, oldest first
  glyph_t fresh_q[$];   // results of the byte just decoded

  int  errors = 0;
  int  bytes_sent;
  int  chars_checked = 0;
  int  ends_seen = 0;
  int  pairs_seen = 0;
  int  stuck;
  bit  idle_on;
  int  stall_left;

  glyph_t mon_got;
  glyph_t mon_want;

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Folding: Latin-1 letters come in upper/lower halves 0x20 apart, so look
  // up the upper-case form by the low five bits and lowercase on bit 5.
  // Extended-A letters come in upper/lower pairs; most pairs start on an
  // even code, the two runs 0x139-0x148 and 0x179-0x17E start on an odd one.
  // --------------------------------------------------------------------------
  function automatic letters_t fold_point(input logic [u8fa_pkg::CP_W-1:0] code);
    logic [7:0] a;
    logic [7:0] b;
    logic       lower;
    letters_t   r;
    a     = u8fa_pkg::CH_QMARK;
    b     = 8'h00;
    lower = 1'b0;
    if (code >= 21'h0C0 && code <= 21'h0FF) begin
      lower = code[5];
      case (code[4:0])
        5'h00, 5'h01, 5'h02, 5'h03, 5'h05: a = "A";
        5'h04: begin a = "A"; b = "e"; end
        5'h06: begin a = "A"; b = "E"; end
        5'h07: a = "C";
        5'h08, 5'h09, 5'h0A, 5'h0B: a = "E";
        5'h0C, 5'h0D, 5'h0E, 5'h0F: a = "I";
        5'h11: a = "N";
        5'h12, 5'h13, 5'h14, 5'h15, 5'h18: a = "O";
        5'h16: begin a = "O"; b = "e"; end
        5'h19, 5'h1A, 5'h1B: a = "U";
        5'h1C: begin a = "U"; b = "e"; end
        5'h1D: a = "Y";
        5'h1F: begin
          // upper half holds sharp s, lower half y with diaeresis
          if (lower) begin
            a = "Y";
          end else begin
            a = "s";
            b = "s";
          end
        end
        default: a = u8fa_pkg::CH_QMARK;
      endcase
    end else if (code >= 21'h100 && code <= 21'h17F) begin
      lower = code[0] ^ ((code >= 21'h139 && code <= 21'h148) ||
                         (code >= 21'h179 && code <= 21'h17E));
      case (code[8:0])
        9'h102, 9'h103, 9'h104, 9'h105: a = "A";
        9'h106, 9'h107, 9'h10C, 9'h10D: a = "C";
        9'h10E, 9'h10F, 9'h110, 9'h111: a = "D";
        9'h118, 9'h119, 9'h11A, 9'h11B: a = "E";
        9'h141, 9'h142: a = "L";
        9'h143, 9'h144, 9'h147, 9'h148: a = "N";
        9'h150, 9'h151: a = "O";
        9'h158, 9'h159: a = "R";
        9'h15A, 9'h15B, 9'h160, 9'h161: a = "S";
        9'h164, 9'h165: a = "T";
        9'h16E, 9'h16F, 9'h170, 9'h171: a = "U";
        9'h179, 9'h17A, 9'h17B, 9'h17C, 9'h17D, 9'h17E: a = "Z";
        default: a = u8fa_pkg::CH_QMARK;
      endcase
    end
    if (lower && a != u8fa_pkg::CH_QMARK) begin
      a[5] = 1'b1;
      b[5] = (b != 8'h00);
    end
    r.two    = (b != 8'h00);
    r.first  = a[6:0];
    r.second = b[6:0];
    return r;
  endfunction

  // Advance the decoder by one byte and leave its results in fresh_q.
  task automatic decode_byte(input logic [7:0] b, input logic last);
    letters_t lt;
    int       n;
    n = 0;
    lt = '0;
    fresh_q.delete();
    if (cont_left == 2'd0) begin
      if (!b[7]) begin
        lt.first = (b >= u8fa_pkg::CH_SPACE && b < u8fa_pkg::CH_DEL) ? b[6:0]
                                                                  : u8fa_pkg::CH_SPACE[6:0];
        n = 1;
      end else if (b[7:5] == 3'b110) begin
        cp_acc = u8fa_pkg::CP_W'(b[4:0]);
        cont_left = 2'd1;
        seq_broken = 1'b0;
      end else if (b[7:4] == 4'b1110) begin
        cp_acc = u8fa_pkg::CP_W'(b[3:0]);
        cont_left = 2'd2;
        seq_broken = 1'b0;
      end else if (b[7:3] == 5'b11110) begin
        cp_acc = u8fa_pkg::CP_W'(b[2:0]);
        cont_left = 2'd3;
        seq_broken = 1'b0;
      end
      // anything else outside a sequence is a stray byte: drop it
    end else begin
      if (b[7:6] != 2'b10) begin
        seq_broken = 1'b1;
      end else if (!seq_broken) begin
        cp_acc = {cp_acc[u8fa_pkg::CP_W-7:0], b[5:0]};
      end
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        if (!seq_broken) begin
          lt = fold_point(cp_acc);
          n = lt.two ? 2 : 1;
        end
        cp_acc = '0;
        seq_broken = 1'b0;
      end
    end
    // end of text clears whatever is still open
    if (last) begin
      cp_acc = '0;
      cont_left = 2'd0;
      seq_broken = 1'b0;
    end
    if (n == 0) begin
      if (last) fresh_q.insert(fresh_q.size(), END_MARK);
    end else if (n == 1) begin
      fresh_q.insert(fresh_q.size(), {lt.first, 1'b1, 1'b1, last});
    end else begin
      fresh_q.insert(fresh_q.size(), {lt.first, 1'b1, 1'b0, 1'b0});
      fresh_q.insert(fresh_q.size(), {lt.second, 1'b1, 1'b1, last});
    end
  endtask

  // Offer one byte, with an occasional gap first; return after its transfer.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.text_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic flag_field(input string name, input logic [7:0] want_v,
                            input logic [7:0] got_v);
    errors++;
    $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
  endtask

  // Result side: random stall bursts while idling is on, ready held high
  // otherwise.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (!idle_on) begin
      out_ch.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check every result transfer against the oldest result still owed.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      mon_got = {out_ch.ascii_char, out_ch.has_char, out_ch.run_last, out_ch.text_end};
      if (glyph_q.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing owed, expected none, got 0x%0h",
                 $time, mon_got);
      end else begin
        mon_want = glyph_q.pop_front();
        chars_checked++;
        if (mon_got.ascii_char !== mon_want.ascii_char)
          flag_field("ascii_char", 8'(mon_want.ascii_char), 8'(mon_got.ascii_char));
        if (mon_got.has_char !== mon_want.has_char)
          flag_field("has_char", 8'(mon_want.has_char), 8'(mon_got.has_char));
        if (mon_got.run_last !== mon_want.run_last)
          flag_field("run_last", 8'(mon_want.run_last), 8'(mon_got.run_last));
        if (mon_got.text_end !== mon_want.text_end)
          flag_field("text_end", 8'(mon_want.text_end), 8'(mon_got.text_end));
        if (mon_want.text_end) ends_seen++;
        if (!mon_want.run_last) pairs_seen++;
      end
    end
  end

  // Count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    wait (stuck >= WATCHDOG);
    $display("%0t ns: no transfer for %0d cycles, %0d results still owed",
             $time, WATCHDOG, glyph_q.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [7:0] unit_q[$];
    logic [7:0] lead;
    int         kind;
    int         len;
    int         bad_at;
    int         counted;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.text_byte = 8'h00;
    in_ch.text_last = 1'b0;
    cp_acc          = '0;
    cont_left       = 2'd0;
    seq_broken      = 1'b0;
    bytes_sent      = 0;
    idle_on         = 1'b1;
    counted         = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: typed rows override the decoder's expectation, but
    // the decoder still advances so its state tracks the block.
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_byte(DIRECTED[i].text_byte, DIRECTED[i].text_last);
      decode_byte(DIRECTED[i].text_byte, DIRECTED[i].text_last);
      if (DIRECTED[i].typed) begin
        glyph_q.insert(glyph_q.size(), DIRECTED[i].want);
      end else begin
        foreach (fresh_q[k]) glyph_q.insert(glyph_q.size(), fresh_q[k]);
      end
    end

    // Random texts: mostly well-formed sequences with random payload, some
    // broken sequences and stray bytes; an end flag may land anywhere,
    // including inside a sequence.
    while (counted < N_RANDOM) begin
      if (counted >= CALM_FROM) begin
        idle_on = 1'b0;
      end else if ($urandom_range(0, 24) == 0) begin
        idle_on = !idle_on;
      end
      unit_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        unit_q.insert(unit_q.size(), 8'($urandom_range(0, 127)));
      end else if (kind < 55) begin
        // lean on C3/C4/C5 leads so the folding tables get exercised
        lead = ($urandom_range(0, 1) != 0) ? 8'(8'hC3 + $urandom_range(0, 2))
                                           : 8'(8'hC0 | $urandom_range(0, 31));
        unit_q.insert(unit_q.size(), lead);
        unit_q.insert(unit_q.size(), 8'(8'h80 | $urandom_range(0, 63)));
      end else if (kind < 70) begin
        unit_q.insert(unit_q.size(), 8'(8'hE0 | $urandom_range(0, 15)));
        repeat (2) unit_q.insert(unit_q.size(), 8'(8'h80 | $urandom_range(0, 63)));
      end else if (kind < 80) begin
        unit_q.insert(unit_q.size(), 8'(8'hF0 | $urandom_range(0, 7)));
        repeat (3) unit_q.insert(unit_q.size(), 8'(8'h80 | $urandom_range(0, 63)));
      end else if (kind < 92) begin
        len = $urandom_range(2, 4);
        bad_at = $urandom_range(1, len - 1);
        case (len)
          2:       unit_q.insert(unit_q.size(), 8'(8'hC0 | $urandom_range(0, 31)));
          3:       unit_q.insert(unit_q.size(), 8'(8'hE0 | $urandom_range(0, 15)));
          default: unit_q.insert(unit_q.size(), 8'(8'hF0 | $urandom_range(0, 7)));
        endcase
        for (int i = 1; i < len; i++) begin
          if (i == bad_at) begin
            unit_q.insert(unit_q.size(),
                          ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 127))
                                                      : 8'($urandom_range(192, 255)));
          end else if (i > bad_at) begin
            unit_q.insert(unit_q.size(), 8'($urandom_range(0, 255)));
          end else begin
            unit_q.insert(unit_q.size(), 8'(8'h80 | $urandom_range(0, 63)));
          end
        end
      end else begin
        unit_q.insert(unit_q.size(),
                      ($urandom_range(0, 1) != 0) ? 8'($urandom_range(128, 191))
                                                  : 8'($urandom_range(248, 255)));
      end
      foreach (unit_q[i]) begin
        logic last_bit;
        last_bit = ($urandom_range(0, 15) == 0);
        send_byte(unit_q[i], last_bit);
        decode_byte(unit_q[i], last_bit);
        foreach (fresh_q[k]) glyph_q.insert(glyph_q.size(), fresh_q[k]);
      end
      // stray bytes yield no character from the block, so they do not count
      if (kind < 92) counted += unit_q.size();
    end
    in_ch.valid <= 1'b0;

    // Wait for every owed result, then hold a little longer to catch extras.
    while (glyph_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Run covered %0d input bytes and %0d checked results", bytes_sent, chars_checked);
    $display("  including %0d text ends and %0d two-letter folds", ends_seen, pairs_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
